FILE: rtl/cua_pkg.sv
// Shared types and codes for the contiguous unit allocator.
package cua_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_COMPACT = 2'd1,
    MODE_LOAD    = 2'd2,
    MODE_START   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [0:0] {
    REG_POLICY = 1'b0,
    REG_UNITS  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN2,
    ST_FILL,
    ST_CWRITE,
    ST_FINISH
  } state_t;

  // what a write sweep puts into the map
  typedef enum logic [1:0] {
    WK_CLR,
    WK_ONE,
    WK_PACK
  } wkind_t;

  localparam int CFG_DW   = 11;
  localparam int REQ_W    = 11;
  localparam int IDX_W    = 10;
  localparam int TAG_W    = 16;
  localparam int FAIL_W   = 16;
  localparam logic [FAIL_W-1:0] FAIL_MAX = 16'hFFFF;

  typedef struct packed {
    logic   accept;
    logic   scan_go;
    logic   scan_zero;
    logic   fill_go;
    logic   cw_go;
    logic   wr_run;
    wkind_t wkind;
    logic   load_wr;
    logic   ptr_scan;
    logic   count_fail;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic    wlast;
    logic    scan_done;
    logic    hit;
    logic    pick_ok;
    logic    req_ok;
    mode_t   mode;
    policy_t policy;
  } sts_t;

endpackage

FILE: rtl/cua_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cua_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cua_ctrl.sv
// Controller state machine: sequences scans, write sweeps and result hand-off.
module cua_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  cua_pkg::sts_t sts,
  output cua_pkg::cmd_t cmd
);
  import cua_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   first_like;

  assign first_like = (sts.policy == POL_FIRST) || (sts.policy == POL_NEXT);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.wlast) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        case (sts.mode)
          MODE_ALLOC: state_nxt = sts.req_ok ? ST_SCAN : ST_FINISH;
          MODE_LOAD:  state_nxt = ST_FINISH;
          default:    state_nxt = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        case (sts.mode)
          MODE_ALLOC: begin
            if (first_like) begin
              if (sts.hit) state_nxt = ST_FILL;
              else if (sts.scan_done)
                state_nxt = (sts.policy == POL_NEXT) ? ST_SCAN2 : ST_FINISH;
            end else if (sts.scan_done) begin
              state_nxt = sts.pick_ok ? ST_FILL : ST_FINISH;
            end
          end
          MODE_COMPACT: if (sts.scan_done) state_nxt = ST_CWRITE;
          default:      if (sts.scan_done) state_nxt = ST_FINISH;
        endcase
      end
      ST_SCAN2: begin
        if (sts.hit) state_nxt = ST_FILL;
        else if (sts.scan_done) state_nxt = ST_FINISH;
      end
      ST_FILL:   if (sts.wlast) state_nxt = ST_FINISH;
      ST_CWRITE: if (sts.wlast) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.wkind = WK_CLR;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_run = 1'b1;
        cmd.wkind  = WK_CLR;
      end
      ST_IDLE: cmd.accept = in_tvalid;
      ST_DECODE: begin
        case (sts.mode)
          MODE_ALLOC: begin
            cmd.scan_go    = sts.req_ok;
            cmd.scan_zero  = (sts.policy != POL_NEXT);
            cmd.count_fail = !sts.req_ok;
          end
          MODE_LOAD: cmd.load_wr = 1'b1;
          default: begin
            cmd.scan_go   = 1'b1;
            cmd.scan_zero = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        case (sts.mode)
          MODE_ALLOC: begin
            if (first_like) begin
              if (sts.hit) cmd.fill_go = 1'b1;
              else if (sts.scan_done) begin
                // next fit retries once from unit 0
                cmd.scan_go    = (sts.policy == POL_NEXT);
                cmd.scan_zero  = 1'b1;
                cmd.count_fail = (sts.policy != POL_NEXT);
              end
            end else if (sts.scan_done) begin
              cmd.fill_go    = sts.pick_ok;
              cmd.count_fail = !sts.pick_ok;
            end
          end
          MODE_COMPACT: cmd.cw_go = sts.scan_done;
          default:      cmd.ptr_scan = sts.scan_done;
        endcase
      end
      ST_SCAN2: begin
        if (sts.hit) cmd.fill_go = 1'b1;
        else cmd.count_fail = sts.scan_done;
      end
      ST_FILL: begin
        cmd.wr_run = 1'b1;
        cmd.wkind  = WK_ONE;
      end
      ST_CWRITE: begin
        cmd.wr_run = 1'b1;
        cmd.wkind  = WK_PACK;
      end
      ST_FINISH: cmd.load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted word keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.load_out)
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/cua_dp.sv
// Datapath: unit map, scan engine, write sweeps, pointer, counters, result word.
module cua_dp #(
  parameter int UNITS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cua_pkg::cmd_t                 cmd,
  output cua_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [cua_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic [1:0]                    in_mode,
  input  logic [cua_pkg::REQ_W-1:0]     in_req,
  input  logic [cua_pkg::IDX_W-1:0]     in_idx,
  input  logic                          in_full,
  input  logic [cua_pkg::TAG_W-1:0]     in_tag,
  output logic                          res_ok,
  output logic [cua_pkg::IDX_W-1:0]     res_start,
  output logic [cua_pkg::TAG_W-1:0]     res_tag,
  output logic [cua_pkg::FAIL_W-1:0]    res_fail
);
  import cua_pkg::*;

  localparam int IW = $clog2(UNITS);
  localparam int CW = $clog2(UNITS + 1);
  localparam int WW = (CW > REQ_W) ? CW : REQ_W;

  // configuration
  policy_t             policy_r;
  logic [CFG_DW-1:0]   uiu_r;
  // latched item
  mode_t               mode_r;
  logic [REQ_W-1:0]    reqin_r;
  logic [IDX_W-1:0]    idx_r;
  logic                full_r;
  logic [TAG_W-1:0]    tag_r;
  logic [CW-1:0]       req_r;
  // scan engine
  logic                act_r, pv_r, hit_r, first_v_r, pick_v_r;
  logic [CW-1:0]       iss_r, run_r, pick_len_r, fcnt_r;
  logic [IW-1:0]       pos_r, rst_r, first_r, pick_r, hit_at_r;
  // write sweep
  logic [CW-1:0]       wp_r, left_r;
  // allocation state
  logic [IW-1:0]       at_r;
  logic                granted_r;
  logic [CW-1:0]       resume_r;
  logic [FAIL_W-1:0]   fail_r;

  logic [WW-1:0]       uiu_w, n_w, req_w, idx_w;
  logic [CW-1:0]       n_r;
  logic                issue, rbit, empty, last, ev, take, ff_en, ffhit, upd, idx_ok;
  logic [CW-1:0]       nrun, ev_len;
  logic [IW-1:0]       nst, ev_st, at_sel;
  logic                wr_en, wr_data;
  logic [IW-1:0]       wr_addr;

  // managed size, clamped to 1..UNITS
  assign uiu_w = WW'(uiu_r);
  assign n_w   = (uiu_w == '0) ? WW'(1) : ((uiu_w > WW'(UNITS)) ? WW'(UNITS) : uiu_w);
  assign n_r   = CW'(n_w);
  assign req_w = WW'(reqin_r);
  assign idx_w = WW'(idx_r);
  assign idx_ok = idx_w < WW'(UNITS);

  assign sts.req_ok    = (req_w != '0) && (req_w <= n_w);
  assign sts.mode      = mode_r;
  assign sts.policy    = policy_r;
  assign sts.hit       = hit_r;
  assign sts.pick_ok   = pick_v_r;
  assign sts.wlast     = (left_r == CW'(1));
  assign sts.scan_done = act_r && !pv_r && !(iss_r < n_r);

  // scan: issue one read per cycle, process each bit once its registered read data returns
  assign issue = act_r && (iss_r < n_r);
  assign empty = !rbit;
  assign nrun  = run_r + CW'(1);
  assign nst   = (run_r == '0) ? pos_r : rst_r;
  assign last  = (CW'(pos_r) == (n_r - CW'(1)));
  assign ff_en = (mode_r == MODE_ALLOC) &&
                 ((policy_r == POL_FIRST) || (policy_r == POL_NEXT));
  assign upd   = pv_r && !hit_r;
  assign ffhit = upd && ff_en && empty && (nrun == req_r);

  // end of a maximal empty run
  always_comb begin
    ev     = 1'b0;
    ev_len = run_r;
    ev_st  = rst_r;
    if (upd && !empty && (run_r != '0)) begin
      ev = 1'b1;
    end else if (upd && empty && last) begin
      ev     = 1'b1;
      ev_len = nrun;
      ev_st  = nst;
    end
  end

  assign take = ev && (ev_len >= req_r) &&
                (!pick_v_r || ((policy_r == POL_BEST) ? (ev_len < pick_len_r)
                                                      : (ev_len > pick_len_r)));

  assign at_sel = ((policy_r == POL_BEST) || (policy_r == POL_WORST)) ? pick_r : hit_at_r;

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp_r[IW-1:0];
    wr_data = 1'b0;
    if (cmd.wr_run) begin
      wr_en = 1'b1;
      case (cmd.wkind)
        WK_ONE:  wr_data = 1'b1;
        WK_PACK: wr_data = (wp_r < fcnt_r);
        default: wr_data = 1'b0;
      endcase
    end else if (cmd.load_wr && idx_ok) begin
      wr_en   = 1'b1;
      wr_addr = idx_w[IW-1:0];
      wr_data = full_r;
    end
  end

  cua_ram #(.WIDTH(1), .DEPTH(UNITS)) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (iss_r[IW-1:0]),
    .rdata (rbit)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      uiu_r    <= CFG_DW'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POLICY: policy_r <= policy_t'(cfg_wdata[1:0]);
        REG_UNITS:  uiu_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= mode_t'(in_mode);
      reqin_r <= in_req;
      idx_r   <= in_idx;
      full_r  <= in_full;
      tag_r   <= in_tag;
    end
    if (cmd.scan_go) begin
      req_r <= CW'(req_w);
    end
  end

  // scan engine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      pv_r  <= 1'b0;
      hit_r <= 1'b0;
    end else if (cmd.scan_go) begin
      act_r <= 1'b1;
      pv_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      pv_r <= issue;
      if (ffhit) hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go) begin
      iss_r      <= cmd.scan_zero ? '0 : resume_r;
      run_r      <= '0;
      first_v_r  <= 1'b0;
      pick_v_r   <= 1'b0;
      fcnt_r     <= '0;
    end else begin
      if (issue) iss_r <= iss_r + CW'(1);
      pos_r <= iss_r[IW-1:0];
      if (upd) begin
        if (empty) begin
          run_r <= nrun;
          rst_r <= nst;
          if (!first_v_r) begin
            first_v_r <= 1'b1;
            first_r   <= pos_r;
          end
        end else begin
          run_r  <= '0;
          fcnt_r <= fcnt_r + CW'(1);
        end
        if (take) begin
          pick_v_r   <= 1'b1;
          pick_r     <= ev_st;
          pick_len_r <= ev_len;
        end
        if (ffhit) hit_at_r <= nst;
      end
    end
  end

  // write sweep counters; reset arms the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      left_r <= CW'(UNITS);
    end else if (cmd.fill_go) begin
      wp_r   <= CW'(at_sel);
      left_r <= req_r;
    end else if (cmd.cw_go) begin
      wp_r   <= '0;
      left_r <= n_r;
    end else if (cmd.wr_run) begin
      wp_r   <= wp_r + CW'(1);
      left_r <= left_r - CW'(1);
    end
  end

  // grant, pointer and failure count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resume_r  <= '0;
      fail_r    <= '0;
      granted_r <= 1'b0;
    end else begin
      if (cmd.accept) granted_r <= 1'b0;
      if (cmd.fill_go) begin
        granted_r <= 1'b1;
        if (policy_r == POL_NEXT) resume_r <= CW'(at_sel) + req_r;
      end
      if (cmd.cw_go) resume_r <= (fcnt_r < n_r) ? fcnt_r : '0;
      if (cmd.ptr_scan) begin
        if (run_r != '0) resume_r <= CW'(rst_r);
        else if (first_v_r) resume_r <= CW'(first_r);
        else resume_r <= '0;
      end
      if (cmd.count_fail && (fail_r != FAIL_MAX)) fail_r <= fail_r + FAIL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_go) at_r <= at_sel;
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_ok    <= (mode_r != MODE_ALLOC) || granted_r;
      res_start <= granted_r && (mode_r == MODE_ALLOC) ? IDX_W'(at_r) : '0;
      res_tag   <= tag_r;
      res_fail  <= fail_r;
    end
  end

  // failure count only grows between resets
  a_fail_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fail_r >= $past(fail_r))
    else $error("failure count went down");

  // a granted run stays inside the managed units
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_run && (cmd.wkind == WK_ONE)) |-> (wp_r < n_r))
    else $error("fill beyond managed units");

  // a first-fit or next-fit hit stops further run tracking
  a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && !cmd.scan_go) |=> hit_r)
    else $error("hit dropped during scan");

endmodule

FILE: rtl/contiguous_unit_allocator_top.sv
// Top level of the contiguous unit allocator.
//
//   channel  | ports                         | word
//   ---------+-------------------------------+-------------------------------------
//   input    | in_tvalid/in_tready           | tuser mode, tdata request/unit/tag
//   result   | out_tvalid/out_tready         | tdata success/start/tag/failures
//   config   | cfg_we/cfg_addr/cfg_wdata     | 0 policy, 1 units_in_use
//
// Next fit may retry its scan once from unit 0 when the first pass fails. The scan
// reads one map bit per cycle from the single read port of the unit map RAM.
// After reset a clearing pass writes all UNITS map entries, one per cycle,
// before the first word is taken; config writes are taken throughout.
// A stalled result holds in the output register; a next word may be taken, but its result waits for it.
module contiguous_unit_allocator_top #(
  parameter int UNITS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [39:0] in_tdata,   // request_units, unit_index, unit_full, line_tag, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // success, start_unit, tag_out, failures, pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata
);
  import cua_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              res_ok;
  logic [IDX_W-1:0]  res_start;
  logic [TAG_W-1:0]  res_tag;
  logic [FAIL_W-1:0] res_fail;

  cua_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cua_dp #(.UNITS(UNITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_tuser),
    .in_req    (in_tdata[10:0]),
    .in_idx    (in_tdata[20:11]),
    .in_full   (in_tdata[21]),
    .in_tag    (in_tdata[37:22]),
    .res_ok    (res_ok),
    .res_start (res_start),
    .res_tag   (res_tag),
    .res_fail  (res_fail)
  );

  assign out_tdata = {5'b0, res_fail, res_tag, res_start, res_ok};

endmodule
